// ===== src/assert_macros.svh =====
// Concurrent assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLRLE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clrle: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CLRLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clrle: next-cycle check failed");

`endif

// ===== src/clrle_pkg.sv =====
// Types, constants and helpers for the code-length run-length encoder.
package clrle_pkg;

   localparam int LEN_W        = 4;
   localparam int SYM_W        = 5;
   localparam int EXTRA_VAL_W  = 7;
   localparam int EXTRA_WID_W  = 3;
   localparam int COUNT_W      = 8;

   localparam int MAX_RESULTS  = 3;
   localparam int FLUSH_MAX    = 2;
   localparam int BATCH_CNT_W  = 2;

   localparam int QUEUE_DEPTH  = 8;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SYM_W-1:0] SYM_REP    = 5'd16;
   localparam logic [SYM_W-1:0] SYM_ZSHORT = 5'd17;
   localparam logic [SYM_W-1:0] SYM_ZLONG  = 5'd18;

   localparam logic [COUNT_W-1:0] REP_CHUNK   = 8'd6;
   localparam logic [COUNT_W-1:0] ZERO_CHUNK  = 8'd138;
   localparam logic [COUNT_W-1:0] REP_BASE    = 8'd3;
   localparam logic [COUNT_W-1:0] ZSHORT_BASE = 8'd3;
   localparam logic [COUNT_W-1:0] ZLONG_BASE  = 8'd11;

   localparam logic [EXTRA_WID_W-1:0] LIT_XW    = 3'd0;
   localparam logic [EXTRA_WID_W-1:0] REP_XW    = 3'd2;
   localparam logic [EXTRA_WID_W-1:0] ZSHORT_XW = 3'd3;
   localparam logic [EXTRA_WID_W-1:0] ZLONG_XW  = 3'd7;

   typedef struct packed {
      logic [SYM_W-1:0]       symbol;
      logic [EXTRA_VAL_W-1:0] extra_value;
      logic [EXTRA_WID_W-1:0] extra_width;
      logic                   last_of_item;
      logic                   end_of_list;
   } result_type;

   typedef struct packed {
      logic [BATCH_CNT_W-1:0]          count;
      result_type [MAX_RESULTS-1:0]    entry;
   } batch_type;

   function automatic result_type make_result(logic [SYM_W-1:0] sym,
                                              logic [EXTRA_VAL_W-1:0] ev,
                                              logic [EXTRA_WID_W-1:0] ew);
      result_type r;
      r.symbol       = sym;
      r.extra_value  = ev;
      r.extra_width  = ew;
      r.last_of_item = 1'b0;
      r.end_of_list  = 1'b0;
      return r;
   endfunction

endpackage

// ===== src/clrle_if.sv =====
// Valid/ready channel interfaces for code-length items and encoded symbols.
interface clrle_req_if import clrle_pkg::*;;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] code_length;
   logic             final_item;

   modport source(output valid, output code_length, output final_item, input ready);
   modport sink(input valid, input code_length, input final_item, output ready);
endinterface

interface clrle_rsp_if import clrle_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [SYM_W-1:0]       symbol;
   logic [EXTRA_VAL_W-1:0] extra_value;
   logic [EXTRA_WID_W-1:0] extra_width;
   logic                   last_of_item;
   logic                   end_of_list;

   modport source(output valid, output symbol, output extra_value, output extra_width,
                  output last_of_item, output end_of_list, input ready);
   modport sink(input valid, input symbol, input extra_value, input extra_width,
                input last_of_item, input end_of_list, output ready);
endinterface

// ===== src/code_length_run_length_encoder_unit.sv =====
// The symbols of an item are registered in the result queue before rsp_chan offers them.
// Throughput: one code length per cycle; an item yields zero to three symbols, and the
// eight-entry result queue drains one symbol per cycle while rsp_chan.ready is high, so
// req_chan.ready drops while fewer than three entries are free.
// Reset: synchronous, active high; clears the open run and empties the queue.
module code_length_run_length_encoder_unit import clrle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   clrle_req_if.sink   req_chan,
   clrle_rsp_if.source rsp_chan
);

   logic      room;
   logic      accept;
   batch_type batch;

   assign req_chan.ready = room;
   assign accept         = req_chan.valid && room;

   clrle_encoder u_encoder (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .code_length (req_chan.code_length),
      .final_item  (req_chan.final_item),
      .batch       (batch)
   );

   clrle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .batch    (batch),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== src/clrle_encoder.sv =====
// Run state and per-item symbol generation (up to three symbols per item).
`include "assert_macros.svh"

module clrle_encoder import clrle_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [LEN_W-1:0] code_length,
   input  logic             final_item,
   output batch_type        batch
);

   logic               run_active_ff, run_active_in;
   logic [LEN_W-1:0]   run_value_ff, run_value_in;
   logic [COUNT_W-1:0] run_count_ff, run_count_in;

   function automatic batch_type flush_run(logic active, logic [LEN_W-1:0] value,
                                           logic [COUNT_W-1:0] count);
      batch_type fb;
      fb = '0;
      if (active) begin
         if (value != '0) begin
            if (count >= REP_BASE) begin
               fb.count    = BATCH_CNT_W'(1);
               fb.entry[0] = make_result(SYM_REP, EXTRA_VAL_W'(count - REP_BASE), REP_XW);
            end else begin
               fb.count    = BATCH_CNT_W'(count);
               fb.entry[0] = make_result(SYM_W'(value), '0, LIT_XW);
               fb.entry[1] = make_result(SYM_W'(value), '0, LIT_XW);
            end
         end else begin
            if (count >= ZLONG_BASE) begin
               fb.count    = BATCH_CNT_W'(1);
               fb.entry[0] = make_result(SYM_ZLONG, EXTRA_VAL_W'(count - ZLONG_BASE),
                                         ZLONG_XW);
            end else if (count >= ZSHORT_BASE) begin
               fb.count    = BATCH_CNT_W'(1);
               fb.entry[0] = make_result(SYM_ZSHORT, EXTRA_VAL_W'(count - ZSHORT_BASE),
                                         ZSHORT_XW);
            end else begin
               fb.count    = BATCH_CNT_W'(count);
               fb.entry[0] = make_result('0, '0, LIT_XW);
               fb.entry[1] = make_result('0, '0, LIT_XW);
            end
         end
      end
      return fb;
   endfunction

   always_comb begin
      batch_type              gen;
      batch_type              old_fb;
      batch_type              end_fb;
      logic [BATCH_CNT_W-1:0] n;
      logic                   act;
      logic [LEN_W-1:0]       val;
      logic [COUNT_W-1:0]     cnt;

      gen    = '0;
      old_fb = '0;
      end_fb = '0;
      n      = '0;
      act    = 1'b1;
      val    = code_length;
      cnt    = '0;

      if (run_active_ff && code_length == run_value_ff) begin
         cnt = run_count_ff + 8'd1;
         if (code_length != '0) begin
            if (cnt >= REP_CHUNK) begin
               gen.entry[n] = make_result(SYM_REP, EXTRA_VAL_W'(REP_CHUNK - REP_BASE), REP_XW);
               n   = n + 2'd1;
               cnt = '0;
            end
         end else if (cnt >= ZERO_CHUNK) begin
            gen.entry[n] = make_result(SYM_ZLONG, EXTRA_VAL_W'(ZERO_CHUNK - ZLONG_BASE),
                                       ZLONG_XW);
            n   = n + 2'd1;
            cnt = '0;
         end
      end else begin
         old_fb = flush_run(run_active_ff, run_value_ff, run_count_ff);
         for (int i = 0; i < FLUSH_MAX; i++) begin
            if (BATCH_CNT_W'(i) < old_fb.count) begin
               gen.entry[n] = old_fb.entry[i];
               n = n + 2'd1;
            end
         end
         if (code_length != '0) begin
            gen.entry[n] = make_result(SYM_W'(code_length), '0, LIT_XW);
            n   = n + 2'd1;
            cnt = '0;
         end else begin
            cnt = 8'd1;
         end
      end

      if (final_item) begin
         end_fb = flush_run(act, val, cnt);
         for (int i = 0; i < FLUSH_MAX; i++) begin
            if (BATCH_CNT_W'(i) < end_fb.count) begin
               gen.entry[n] = end_fb.entry[i];
               n = n + 2'd1;
            end
         end
         act = 1'b0;
         val = '0;
         cnt = '0;
      end

      if (n != '0) begin
         gen.entry[n - 2'd1].last_of_item = 1'b1;
         gen.entry[n - 2'd1].end_of_list  = final_item;
      end

      gen.count = accept ? n : '0;
      batch     = gen;

      run_active_in = accept ? act : run_active_ff;
      run_value_in  = accept ? val : run_value_ff;
      run_count_in  = accept ? cnt : run_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         run_value_ff  <= '0;
         run_count_ff  <= '0;
      end else begin
         run_active_ff <= run_active_in;
         run_value_ff  <= run_value_in;
         run_count_ff  <= run_count_in;
      end
   end

   `CLRLE_ASSERT_IMPLY(a_final_has_result, clock, reset, accept && final_item, batch.count != '0)
   `CLRLE_ASSERT_NEXT(a_final_clears_run, clock, reset, accept && final_item, !run_active_ff && run_count_ff == '0)

endmodule

// ===== src/clrle_queue.sv =====
// Result queue: takes up to three symbols per cycle, hands out one per transfer.
`include "assert_macros.svh"

module clrle_queue import clrle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  batch_type  batch,
   output logic       room,
   clrle_rsp_if.source rsp_chan
);

   result_type        slot_ff [QUEUE_DEPTH];
   result_type        slot_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;
   result_type        head;

   assign room = count_ff <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);
   assign head = slot_ff[rd_ptr_ff];

   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.symbol       = head.symbol;
   assign rsp_chan.extra_value  = head.extra_value;
   assign rsp_chan.extra_width  = head.extra_width;
   assign rsp_chan.last_of_item = head.last_of_item;
   assign rsp_chan.end_of_list  = head.end_of_list;

   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      slot_in = slot_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (BATCH_CNT_W'(i) < batch.count) begin
            slot_in[wr_ptr_ff + QPTR_W'(i)] = batch.entry[i];
         end
      end
      wr_ptr_in = wr_ptr_ff + QPTR_W'(batch.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(batch.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CLRLE_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `CLRLE_ASSERT_IMPLY(a_no_overfill, clock, reset, batch.count != '0, count_ff + QCNT_W'(batch.count) <= QCNT_W'(QUEUE_DEPTH))
   `CLRLE_ASSERT_NEXT(a_pop_drains, clock, reset, pop && batch.count == '0, count_ff == $past(count_ff) - QCNT_W'(1))

endmodule
